[design/three_wire_thermometer_master_defines.svh]
// Assertion macros for the three-wire thermometer master.
`ifndef THREE_WIRE_THERMOMETER_MASTER_DEFINES_SVH
`define THREE_WIRE_THERMOMETER_MASTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TWTM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twtm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TWTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twtm: next-cycle check failed");

`endif

[design/twtm_pkg.sv]
// Types and constants for the three-wire thermometer master.
package twtm_pkg;

  localparam int CMD_BITS  = 8;
  localparam int READ_BITS = 16;

  // Register indexes on the configuration port
  localparam logic REG_TICKS_PER_PHASE = 1'b0;

  localparam logic [7:0] TICKS_RESET = 8'd1;

  typedef struct packed {
    logic       mode;
    logic [7:0] command;
    logic       read_reply;
    logic       dq_in;
  } item_t;

  typedef struct packed {
    logic              clk_out;
    logic              rst_out;
    logic              dq_out;
    logic              dq_drive;
    logic              busy_res;
    logic              done_res;
    logic [15:0]       raw_word;
    logic signed [7:0] whole_degrees;
    logic signed [3:0] tenths;
  } result_t;

endpackage

[design/three_wire_thermometer_master.sv]
// Three-wire thermometer master: pin sequencer, config register and result register.
// Each accepted item is one time tick (or a start request when idle) and yields
// exactly one result, which appears in the result register on the following cycle.
// The sequencer takes one item per clock unless the result register is held full:
// only combinational pin/decode logic sits between the request and the result
// register, so the block keeps accepting while a held result is taken in the same
// cycle. After the start request a transaction lasts (1 + 2*8 [+ 2*16]) *
// ticks_per_phase ticks (a setting of 0 counts as 1); a start request while busy is
// a plain tick. Pin levels in each result are those after that tick's update.

`include "three_wire_thermometer_master_defines.svh"

module three_wire_thermometer_master (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  twtm_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output twtm_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SETUP     = 3'd1;
  localparam logic [2:0] PH_SEND_LOW  = 3'd2;
  localparam logic [2:0] PH_SEND_HIGH = 3'd3;
  localparam logic [2:0] PH_READ_LOW  = 3'd4;
  localparam logic [2:0] PH_READ_HIGH = 3'd5;

  logic [7:0]  ticks_per_phase;
  logic [2:0]  phase, phase_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [7:0]  shift_out, shift_out_next;
  logic [15:0] shift_in, shift_in_next;
  logic [7:0]  divider_count, divider_count_next;
  logic        read_pending, read_pending_next;
  logic [15:0] last_word, last_word_next;
  logic        clock_level, clock_level_next;

  logic        accept;
  logic        done;
  logic [7:0]  half;
  logic [7:0]  div_inc;
  logic [4:0]  bit_inc;
  logic        sending;
  logic [8:0]  temp_raw;
  logic [8:0]  temp_mag;
  logic signed [7:0] whole;
  logic signed [3:0] tenth;
  twtm_pkg::result_t result_next;

  logic        reading;
  logic        start_taken;
  logic        result_done;
  logic        setup_shown;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == twtm_pkg::REG_TICKS_PER_PHASE) ? {24'd0, ticks_per_phase}
                                                               : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= twtm_pkg::TICKS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == twtm_pkg::REG_TICKS_PER_PHASE) begin
      ticks_per_phase <= pwdata[7:0];
    end
  end

  // Request side stalls only when the result register is full and held
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign half    = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
  assign div_inc = divider_count + 8'd1;
  assign bit_inc = bit_count + 5'd1;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_out_next     = shift_out;
    shift_in_next      = shift_in;
    divider_count_next = divider_count;
    read_pending_next  = read_pending;
    last_word_next     = last_word;
    clock_level_next   = clock_level;
    done               = 1'b0;
    if (phase == PH_IDLE) begin
      if (item.mode) begin
        shift_out_next     = item.command;
        read_pending_next  = item.read_reply;
        bit_count_next     = 5'd0;
        shift_in_next      = 16'd0;
        divider_count_next = 8'd0;
        clock_level_next   = 1'b1;
        phase_next         = PH_SETUP;
      end
    end else begin
      // sample on the first tick after the falling edge
      if (phase == PH_READ_LOW && divider_count == 8'd0) begin
        shift_in_next = shift_in | (16'(item.dq_in) << bit_count[3:0]);
      end
      divider_count_next = div_inc;
      if (div_inc >= half) begin
        divider_count_next = 8'd0;
        case (phase)
          PH_SETUP: begin
            bit_count_next   = 5'd0;
            clock_level_next = 1'b0;
            phase_next       = PH_SEND_LOW;
          end
          PH_SEND_LOW: begin
            clock_level_next = 1'b1;
            phase_next       = PH_SEND_HIGH;
          end
          PH_SEND_HIGH: begin
            bit_count_next = bit_inc;
            shift_out_next = shift_out >> 1;
            if (bit_inc < 5'(twtm_pkg::CMD_BITS)) begin
              clock_level_next = 1'b0;
              phase_next       = PH_SEND_LOW;
            end else if (read_pending) begin
              bit_count_next   = 5'd0;
              clock_level_next = 1'b0;
              phase_next       = PH_READ_LOW;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
          PH_READ_LOW: begin
            clock_level_next = 1'b1;
            phase_next       = PH_READ_HIGH;
          end
          PH_READ_HIGH: begin
            bit_count_next = bit_inc;
            if (bit_inc < 5'(twtm_pkg::READ_BITS)) begin
              clock_level_next = 1'b0;
              phase_next       = PH_READ_LOW;
            end else begin
              last_word_next = shift_in;
              phase_next     = PH_IDLE;
              done           = 1'b1;
            end
          end
          default: begin
            phase_next       = PH_IDLE;
            clock_level_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Decode low 9 bits as two's complement half-degrees, truncating toward zero
  assign temp_raw = last_word_next[8:0];
  assign temp_mag = temp_raw[8] ? (9'd0 - temp_raw) : temp_raw;

  always_comb begin
    if (temp_raw[8]) begin
      whole = 8'(9'd0 - {1'b0, temp_mag[8:1]});
      tenth = temp_mag[0] ? -4'sd5 : 4'sd0;
    end else begin
      whole = 8'(temp_mag[8:1]);
      tenth = temp_mag[0] ? 4'sd5 : 4'sd0;
    end
  end

  assign sending = (phase_next == PH_SEND_LOW) || (phase_next == PH_SEND_HIGH);

  always_comb begin
    result_next.clk_out       = clock_level_next;
    result_next.rst_out       = (phase_next != PH_IDLE);
    result_next.dq_out        = sending && shift_out_next[0];
    result_next.dq_drive      = sending || (phase_next == PH_SETUP);
    result_next.busy_res      = (phase_next != PH_IDLE);
    result_next.done_res      = done;
    result_next.raw_word      = last_word_next;
    result_next.whole_degrees = whole;
    result_next.tenths        = tenth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= 5'd0;
      shift_out     <= 8'd0;
      shift_in      <= 16'd0;
      divider_count <= 8'd0;
      read_pending  <= 1'b0;
      last_word     <= 16'd0;
      clock_level   <= 1'b1;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_out     <= shift_out_next;
      shift_in      <= shift_in_next;
      divider_count <= divider_count_next;
      read_pending  <= read_pending_next;
      last_word     <= last_word_next;
      clock_level   <= clock_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign reading     = (phase == PH_READ_LOW) || (phase == PH_READ_HIGH);
  assign start_taken = accept && (phase == PH_IDLE) && item.mode;
  assign result_done = result_valid && result.done_res;
  assign setup_shown = result_valid && result.dq_drive && result.clk_out;

  `TWTM_ASSERT_IMPLY(a_idle_clock_high, clk, rst, phase == PH_IDLE, clock_level)
  `TWTM_ASSERT_IMPLY(a_read_count_range, clk, rst, reading, bit_count < 5'(twtm_pkg::READ_BITS))
  `TWTM_ASSERT_IMPLY(a_done_not_busy, clk, rst, result_done, !result.busy_res && !result.dq_drive)
  `TWTM_ASSERT_NEXT(a_start_drives, clk, rst, start_taken, setup_shown)

endmodule
